### rtl/vsh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsh_pkg
// shared types and constants of the vector scatter histogram unit
// ----------------------------------------------------------------------------
package vsh_pkg;

  localparam int GRID_SIZE_DEF = 256;
  localparam logic [15:0] GAIN_RESET = 16'h8000;
  localparam logic [31:0] BIN_MAX = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    REQ_ADD   = 2'd0,
    REQ_READ  = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADDR,
    S_MOD,
    S_CLEAR,
    S_RESP
  } state_t;

endpackage

### rtl/vector_scatter_histogram_unit.sv
`timescale 1ns / 1ps
// add and read results pass through S_ADDR and S_MOD and are then registered on the result channel
// no new add or read is taken until the read-modify-write of the bin memory completes
// clear: all GRID_SIZE*GRID_SIZE bins (65536 at the default) are zeroed, one bin written per cycle, then one result
// reset: the same sweep runs after reset; input waits, configuration writes are taken
// gain_r resets to 0x8000
// ----------------------------------------------------------------------------
// vector_scatter_histogram_unit
// square 2d histogram of q8.8 vectors kept in one synchronous bin memory
// ----------------------------------------------------------------------------
module vector_scatter_histogram_unit
  import vsh_pkg::*;
#(
  parameter int GRID_SIZE = GRID_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic signed [15:0] in_vec_x,
  input  logic signed [15:0] in_vec_y,
  input  logic [7:0]  in_read_row,
  input  logic [7:0]  in_read_col,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_bin_value,
  output logic [1:0]  out_req_echo
);

  localparam int IDX_W = $clog2(GRID_SIZE);
  localparam int ADDR_W = 2 * IDX_W;
  localparam int DEPTH = GRID_SIZE * GRID_SIZE;
  localparam logic signed [17:0] CENTER_S = 18'(GRID_SIZE / 2);
  localparam logic signed [17:0] EDGE_S = 18'(GRID_SIZE - 1);
  localparam logic [IDX_W-1:0] EDGE_IDX = IDX_W'(GRID_SIZE - 1);
  localparam logic [31:0] CENTER_U = 32'(GRID_SIZE / 2);
  localparam logic [31:0] GRID_U = 32'(GRID_SIZE);

  // bin memory
  logic [31:0] bin_mem [DEPTH];

  state_t state_r, state_nxt;

  logic [15:0] gain_r;
  logic [1:0]  req_r;
  logic signed [32:0] prod_x_r, prod_y_r;
  logic [ADDR_W-1:0] rd_addr_r;
  logic        in_range_r;
  logic        axis_r;
  logic [ADDR_W-1:0] addr_r;
  logic [ADDR_W-1:0] clr_cnt_r;
  logic        resp_pend_r;
  logic [31:0] rd_data_r;

  logic        out_valid_r;
  logic [31:0] out_bin_value_r;
  logic [1:0]  out_req_echo_r;

  logic        in_fire;
  logic        slot_free;
  logic        clr_last;
  logic        load_out;
  logic [31:0] res_value;
  logic        mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ADDR_W-1:0] mem_raddr;
  logic [31:0] mem_wdata;
  logic [31:0] rd_inc;

  // scaled index path
  logic signed [17:0] sum_x, sum_y;
  logic [IDX_W-1:0]   col_idx, row_idx;
  logic [ADDR_W-1:0]  add_addr;
  logic [ADDR_W-1:0]  addr_calc;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign clr_last  = (clr_cnt_r == ADDR_W'(DEPTH - 1));

  // floor of the q16.16 product is its top bits, then re-center and clamp
  assign sum_x = {prod_x_r[32], prod_x_r[32:16]} + CENTER_S;
  assign sum_y = {prod_y_r[32], prod_y_r[32:16]} + CENTER_S;

  always_comb begin
    if (sum_x[17]) begin
      col_idx = '0;
    end else if (sum_x > EDGE_S) begin
      col_idx = EDGE_IDX;
    end else begin
      col_idx = sum_x[IDX_W-1:0];
    end
    if (sum_y[17]) begin
      row_idx = '0;
    end else if (sum_y > EDGE_S) begin
      row_idx = EDGE_IDX;
    end else begin
      row_idx = sum_y[IDX_W-1:0];
    end
  end

  assign add_addr  = {row_idx, col_idx};
  assign addr_calc = (req_r == REQ_ADD) ? add_addr : rd_addr_r;
  assign mem_raddr = (state_r == S_ADDR) ? addr_calc : addr_r;

  // saturating +1, shared by the increment and the axis mark
  assign rd_inc = (rd_data_r == BIN_MAX) ? BIN_MAX : rd_data_r + 32'd1;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_req_type)
            REQ_ADD:   state_nxt = S_ADDR;
            REQ_READ:  state_nxt = S_ADDR;
            REQ_CLEAR: state_nxt = S_CLEAR;
            default:   state_nxt = S_RESP;
          endcase
        end
      end
      S_ADDR: state_nxt = S_MOD;
      S_MOD: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_CLEAR: begin
        if (clr_last) begin
          state_nxt = resp_pend_r ? S_RESP : S_IDLE;
        end
      end
      S_RESP: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    in_ready  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = addr_r;
    mem_wdata = rd_inc;
    load_out  = 1'b0;
    res_value = '0;
    case (state_r)
      S_IDLE: in_ready = 1'b1;
      S_ADDR: ;
      S_MOD: begin
        load_out = slot_free;
        // write back only when the transaction completes, so a stall rereads the old count
        mem_we = slot_free && (req_r == REQ_ADD);
        if (req_r == REQ_READ && in_range_r) begin
          res_value = axis_r ? rd_inc : rd_data_r;
        end
      end
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        mem_wdata = '0;
      end
      S_RESP: load_out = slot_free;
      default: ;
    endcase
  end

  // memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      bin_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= bin_mem[mem_raddr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      resp_pend_r <= 1'b0;
      gain_r      <= GAIN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        gain_r <= cfg_data;
      end
      if (state_r == S_CLEAR) begin
        clr_cnt_r <= clr_last ? '0 : clr_cnt_r + ADDR_W'(1);
      end
      if (in_fire) begin
        resp_pend_r <= 1'b1;
      end else if (load_out) begin
        resp_pend_r <= 1'b0;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r      <= in_req_type;
      prod_x_r   <= 33'(in_vec_x) * $signed(33'({1'b0, gain_r}));
      prod_y_r   <= 33'(in_vec_y) * $signed(33'({1'b0, gain_r}));
      rd_addr_r  <= {IDX_W'(in_read_row), IDX_W'(in_read_col)};
      in_range_r <= (32'(in_read_row) < GRID_U) && (32'(in_read_col) < GRID_U);
      axis_r     <= (32'(in_read_row) == CENTER_U) || (32'(in_read_col) == CENTER_U);
    end
    if (state_r == S_ADDR) begin
      addr_r <= addr_calc;
    end
    if (load_out) begin
      out_bin_value_r <= res_value;
      out_req_echo_r  <= req_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_bin_value = out_bin_value_r;
  assign out_req_echo  = out_req_echo_r;

`ifndef ASSERT_OFF
  // a result only appears from the modify step or the response step
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_MOD || state_r == S_RESP))
    else $error("result loaded outside a completing state");

  // no transaction is taken while the bins are being swept
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> !in_ready)
    else $error("input accepted during clear sweep");

  // a saturating increment never wraps to zero
  a_inc_no_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && state_r == S_MOD) |-> (mem_wdata != '0))
    else $error("bin increment wrapped");

  // an accepted transaction always leaves idle on the next cycle
  a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r != S_IDLE)
    else $error("accepted transaction did not start");
`endif

endmodule
